FILE: hw/rtl/rus_pkg.sv
// ----------------------------------------------------------------------------
// rus_pkg: shared types and constants of the RGB 3x3 unsharp mask
// Configuration layout, register indexes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rus_pkg;

  localparam int SHARP_W = 5;
  localparam int IW_W    = 11;
  localparam int IH_W    = 16;
  localparam int PIX_W   = 24;
  localparam int CFG_DW  = 16;
  localparam int CFG_AW  = 2;

  localparam logic [CFG_AW-1:0] REG_SHARPNESS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [SHARP_W-1:0] SHARP_RST = 5'd2;
  localparam logic [IW_W-1:0]    IW_RST    = 11'd640;
  localparam logic [IH_W-1:0]    IH_RST    = 16'd480;

  // Smallest frame dimension the block works with.
  localparam int MIN_DIM = 3;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Queue between front and back; depth is a power of two.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [SHARP_W-1:0] sharpness;
    logic [IW_W-1:0]    image_width;
    logic [IH_W-1:0]    image_height;
  } cfg_t;

  // Pixels are packed red high, blue low inside the datapath.
  typedef struct packed {
    logic             is_pixel;  // shifts the window
    logic             has1;      // produces the window result
    logic             has2;      // produces the row-end or drain result
    logic             pass;      // window result passes the centre through
    logic             row_end;
    logic             fin;       // last pixel of the frame (drain only)
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;       // middle row pixel, or drained pixel
    logic [PIX_W-1:0] px;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rus_ram.sv
// ----------------------------------------------------------------------------
// rus_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rus_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rus_front.sv
// ----------------------------------------------------------------------------
// rus_front: item intake, position tracking and line stores
// Accepts items, classifies them, reads and updates both line stores and
// pushes one entry per item that leads to results or a window shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rus_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rus_pkg::cfg_t             cfg,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [23:0]               s_tdata,   // red, green, blue
  input  wire logic                      s_tuser,   // op
  input  wire logic [rus_pkg::QCW-1:0]   q_count,
  output logic                           push,
  output rus_pkg::entry_t                entry
);

  import rus_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > IW_W) ? WW : IW_W;

  logic [AW-1:0]   column_pos;
  logic [IH_W-1:0] row_pos;
  logic [AW-1:0]   drain_pos;
  logic            clearing;
  logic [AW-1:0]   clr_addr;

  logic             s1_valid;
  logic             s1_pix;
  logic [AW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_px;
  logic             s1_has1;
  logic             s1_has2;
  logic             s1_pass;
  logic             s1_row_end;
  logic             s1_fin;

  logic [EW-1:0]    iw_ext;
  logic [WW-1:0]    w_eff;
  logic [AW-1:0]    wm1;
  logic [IH_W-1:0]  h_eff;
  logic             waiting;
  logic             accept;
  logic             do_pix;
  logic             do_drn;
  logic [AW-1:0]    col_c;
  logic             row_end;
  logic [AW-1:0]    drn_a;
  logic             fin;
  logic [PIX_W-1:0] px;

  logic             new_we;
  logic [AW-1:0]    new_waddr;
  logic [PIX_W-1:0] new_wdata;
  logic [AW-1:0]    new_raddr;
  logic [PIX_W-1:0] new_rdata;
  logic             old_we;
  logic [AW-1:0]    old_waddr;
  logic [PIX_W-1:0] old_wdata;
  logic [PIX_W-1:0] old_rdata;

  assign iw_ext = EW'(cfg.image_width);

  always_comb begin
    if (iw_ext > EW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (iw_ext < EW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else begin
      w_eff = WW'(iw_ext);
    end
  end

  assign wm1     = AW'(w_eff - WW'(1));
  assign h_eff   = (cfg.image_height < IH_W'(MIN_DIM)) ? IH_W'(MIN_DIM) : cfg.image_height;
  assign waiting = row_pos >= h_eff;

  assign s_tready = !clearing &&
                    ((QCW + 1)'(q_count) + (QCW + 1)'(s1_valid) < (QCW + 1)'(QDEPTH));
  assign accept   = s_tvalid && s_tready;
  assign do_pix   = accept && !s_tuser && !waiting;
  assign do_drn   = accept && s_tuser && waiting;

  // A column position at or past the last column ends the row.
  assign row_end = column_pos >= wm1;
  assign col_c   = row_end ? wm1 : column_pos;
  assign fin     = drain_pos >= wm1;
  assign drn_a   = fin ? wm1 : drain_pos;
  assign px      = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

  // The newer store takes the pixel right away; the older store takes the
  // pixel it displaced in the following cycle, once the read data is back.
  assign new_we    = clearing || do_pix;
  assign new_waddr = clearing ? clr_addr : col_c;
  assign new_wdata = clearing ? '0 : px;
  assign new_raddr = do_drn ? drn_a : col_c;
  assign old_we    = clearing || (s1_valid && s1_pix);
  assign old_waddr = clearing ? clr_addr : s1_col;
  assign old_wdata = clearing ? '0 : new_rdata;

  rus_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_newer (
    .clk   (clk),
    .we    (new_we),
    .waddr (new_waddr),
    .wdata (new_wdata),
    .raddr (new_raddr),
    .rdata (new_rdata)
  );

  rus_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older (
    .clk   (clk),
    .we    (old_we),
    .waddr (old_waddr),
    .wdata (old_wdata),
    .raddr (col_c),
    .rdata (old_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      drain_pos  <= '0;
      clearing   <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= do_pix || do_drn;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (do_pix) begin
        if (row_end) begin
          column_pos <= '0;
          row_pos    <= row_pos + IH_W'(1);
        end else begin
          column_pos <= col_c + AW'(1);
        end
      end
      if (do_drn) begin
        if (fin) begin
          column_pos <= '0;
          row_pos    <= '0;
          drain_pos  <= '0;
        end else begin
          drain_pos <= drn_a + AW'(1);
        end
      end
    end
  end

  // Only the first output row and the first output column pass through here:
  // the last row leaves through drain and the last column as a row-end item.
  always_ff @(posedge clk) begin
    s1_pix     <= !s_tuser;
    s1_col     <= col_c;
    s1_px      <= px;
    s1_has1    <= !s_tuser && (row_pos != '0) && (col_c != '0);
    s1_has2    <= s_tuser || ((row_pos != '0) && row_end);
    s1_pass    <= (row_pos == IH_W'(1)) || (col_c == AW'(1));
    s1_row_end <= row_end;
    s1_fin     <= s_tuser && fin;
  end

  assign push           = s1_valid;
  assign entry.is_pixel = s1_pix;
  assign entry.has1     = s1_has1;
  assign entry.has2     = s1_has2;
  assign entry.pass     = s1_pass;
  assign entry.row_end  = s1_row_end;
  assign entry.fin      = s1_fin;
  assign entry.top      = old_rdata;
  assign entry.mid      = new_rdata;
  assign entry.px       = s1_px;

endmodule

`default_nettype wire

FILE: hw/rtl/rus_queue.sv
// ----------------------------------------------------------------------------
// rus_queue: short entry queue between front and back
// A small register FIFO that lets front and back stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rus_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire rus_pkg::entry_t          entry_in,
  input  wire logic                     pop,
  output rus_pkg::entry_t               head,
  output logic                          nonempty,
  output logic [rus_pkg::QCW-1:0]       count
);

  import rus_pkg::*;

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head     = mem[rd_ptr];
  assign nonempty = count != '0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCW'(QDEPTH) || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: hw/rtl/rus_back.sv
// ----------------------------------------------------------------------------
// rus_back: window, sharpening and result output
// Pops queue entries, shifts the 3x3 window, sharpens or passes pixels
// through and presents results from an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rus_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rus_pkg::SHARP_W-1:0]   sharpness,
  input  wire logic                          q_valid,
  input  wire rus_pkg::entry_t               q_head,
  output logic                               pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [23:0]                        m_tdata,  // red, green, blue
  output logic                               m_tlast,  // run_last
  output logic                               m_tuser   // frame_last
);

  import rus_pkg::*;

  // Window index is row*3+col, row 0 oldest, col 0 oldest.
  logic [PIX_W-1:0] win [9];

  logic             h_valid;
  logic             h_n1;
  logic             h_n2;
  logic             h_pass;
  logic             h_row_end;
  logic             h_fin;
  logic [PIX_W-1:0] h_mid;

  logic             o_valid;
  logic [PIX_W-1:0] o_data;
  logic             o_rl;
  logic             o_fl;

  logic             o_free;
  logic             emit;
  logic             last;
  logic [PIX_W-1:0] sharp;
  logic [PIX_W-1:0] res1;

  function automatic logic [7:0] sharp_chan(input logic [63:0] nb, input logic [7:0] ctr,
                                            input logic [SHARP_W-1:0] s);
    logic [10:0]        sum;
    logic [7:0]         avg;
    logic signed [9:0]  d;
    logic signed [10:0] dd;
    logic signed [11:0] v;
    logic [7:0]         r;
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + 11'(nb[k*8 +: 8]);
    end
    avg = sum[10:3];
    d   = $signed({2'b00, ctr}) - $signed({2'b00, avg});
    // A zero difference counts as positive.
    if (d < 0) begin
      dd = 11'(d) - $signed(11'(s));
    end else begin
      dd = 11'(d) + $signed(11'(s));
    end
    v = $signed({4'b0000, ctr}) + 12'(dd);
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0000, CHAN_MAX})) begin
      r = CHAN_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  always_comb begin
    logic [63:0] nb;
    for (int ch = 0; ch < 3; ch++) begin
      nb = {win[8][ch*8 +: 8], win[7][ch*8 +: 8], win[6][ch*8 +: 8], win[5][ch*8 +: 8],
            win[3][ch*8 +: 8], win[2][ch*8 +: 8], win[1][ch*8 +: 8], win[0][ch*8 +: 8]};
      sharp[ch*8 +: 8] = sharp_chan(nb, win[4][ch*8 +: 8], sharpness);
    end
  end

  assign res1   = h_pass ? win[4] : sharp;
  assign o_free = !o_valid || m_tready;
  assign emit   = h_valid && o_free;
  assign last   = emit && !(h_n1 && h_n2);
  // The window may only shift once the held item has used it.
  assign pop    = q_valid && (!h_valid || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      h_valid <= 1'b0;
    end else begin
      if (o_free) begin
        o_valid <= emit;
      end
      if (last) begin
        h_valid <= 1'b0;
      end
      if (pop) begin
        h_valid <= q_head.has1 || q_head.has2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (h_n1) begin
        o_data <= res1;
        o_rl   <= !h_row_end;
        o_fl   <= 1'b0;
        h_n1   <= 1'b0;
      end else begin
        o_data <= h_mid;
        o_rl   <= 1'b1;
        o_fl   <= h_fin;
        h_n2   <= 1'b0;
      end
    end
    if (pop) begin
      h_n1      <= q_head.has1;
      h_n2      <= q_head.has2;
      h_pass    <= q_head.pass;
      h_row_end <= q_head.row_end;
      h_fin     <= q_head.fin;
      h_mid     <= q_head.mid;
      if (q_head.is_pixel) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3 + 0] <= win[k*3 + 1];
          win[k*3 + 1] <= win[k*3 + 2];
        end
        win[2] <= q_head.top;
        win[5] <= q_head.mid;
        win[8] <= q_head.px;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_data[7:0], o_data[15:8], o_data[23:16]};
  assign m_tlast  = o_rl;
  assign m_tuser  = o_fl;

  a_hold_nonempty: assert property (@(posedge clk) disable iff (rst)
    h_valid |-> (h_n1 || h_n2))
    else $error("held item has no pending result");

  a_no_pop_midway: assert property (@(posedge clk) disable iff (rst)
    (h_valid && h_n1 && h_n2) |-> !pop)
    else $error("window shifted before the held item finished");

  a_frame_end_ends_run: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_fl) |-> o_rl)
    else $error("frame end without run end");

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_unsharp_3x3.sv
// ----------------------------------------------------------------------------
// rgb_unsharp_3x3: streaming 3x3 unsharp mask on 24-bit RGB pixels
// Configuration registers, front intake, entry queue and result back end.
// ----------------------------------------------------------------------------
// The block takes one item per clock in steady state unless the output stalls;
// each item passes the line-store read stage and the queue before its first
// result leaves the output register. A pixel at the end of a row after the
// first causes two results, sent one after the other, and the four-entry
// queue absorbs that. After reset the block clears all MAX_WIDTH entries of
// both line stores, one entry per cycle, before it takes the first item;
// configuration writes are taken during that time. Output lags input by
// one row and one pixel, and the last row leaves on drain items (tuser high).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_unsharp_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rus_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [rus_pkg::CFG_DW-1:0]   cfg_wdata,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [23:0]                  s_tdata,   // red_in, green_in, blue_in
  input  wire logic                         s_tuser,   // op
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [23:0]                       m_tdata,   // red_out, green_out, blue_out
  output logic                              m_tlast,   // run_last
  output logic                              m_tuser    // frame_last
);

  import rus_pkg::*;

  cfg_t           cfg;
  logic           push;
  entry_t         entry;
  entry_t         q_head;
  logic           q_valid;
  logic [QCW-1:0] q_count;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sharpness    <= SHARP_RST;
      cfg.image_width  <= IW_RST;
      cfg.image_height <= IH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHARPNESS: cfg.sharpness    <= cfg_wdata[SHARP_W-1:0];
        REG_WIDTH:     cfg.image_width  <= cfg_wdata[IW_W-1:0];
        REG_HEIGHT:    cfg.image_height <= cfg_wdata[IH_W-1:0];
        default:       cfg <= cfg;
      endcase
    end
  end

  rus_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_count  (q_count),
    .push     (push),
    .entry    (entry)
  );

  rus_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry_in (entry),
    .pop      (pop),
    .head     (q_head),
    .nonempty (q_valid),
    .count    (q_count)
  );

  rus_back u_back (
    .clk       (clk),
    .rst       (rst),
    .sharpness (cfg.sharpness),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

FILE: verif/tb_rgb_unsharp_3x3.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgb_unsharp_3x3: self-checking bench for the RGB 3x3 unsharp mask
// A short directed table and then randomized frames drive the pixel stream,
// with random idling on both sides. A behavioral model of the line stores,
// the window and the sharpening math predicts the output pixels that the
// table does not type in, and the output is compared in order against them.
// ---------------------------------------------------------------------------
module tb_rgb_unsharp_3x3;
  import rus_pkg::*;

  localparam int STORE_DEPTH   = 1024;
  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int MAX_REPORTS   = 60;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    logic run_last;
    logic frame_last;
  } res_t;

  // How a table row's results are known: from the predictor, or typed in.
  typedef enum logic [1:0] { EXP_MODEL, EXP_NONE, EXP_ONE } exp_kind_e;
  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic              op;
    pix_t              pix;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
    exp_kind_e         ek;
    res_t              er;
  } stim_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;   // red_in, green_in, blue_in
  logic              s_tuser = 1'b0; // op
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;        // red_out, green_out, blue_out
  logic              m_tlast;        // run_last
  logic              m_tuser;        // frame_last

  rgb_unsharp_3x3 uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // Predictor state: configuration, both line stores, window and positions.
  logic [4:0]  sharp_q  = 5'd2;
  logic [10:0] width_q  = 11'd640;
  logic [15:0] height_q = 16'd480;
  pix_t        older_row [STORE_DEPTH];
  pix_t        newer_row [STORE_DEPTH];
  pix_t        win [9];
  int          col_pos   = 0;
  int          row_pos   = 0;
  int          drain_pos = 0;

  res_t        expected_pixels [$];
  stim_row_t   directed_rows [$];
  int          errors    = 0;
  int          cycles    = 0;
  int          gen_count = 0;
  bit          calm      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_unsharp_3x3 regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : out_check
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.pix.r      = m_tdata[7:0];
      got.pix.g      = m_tdata[15:8];
      got.pix.b      = m_tdata[23:16];
      got.run_last   = m_tlast;
      got.frame_last = m_tuser;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected item r=%h g=%h b=%h last=%b frame_last=%b", $time,
                   got.pix.r, got.pix.g, got.pix.b, got.run_last, got.frame_last);
      end else begin
        want = expected_pixels.pop_front();
        if (got.pix.r !== want.pix.r || got.pix.g !== want.pix.g ||
            got.pix.b !== want.pix.b || got.run_last !== want.run_last ||
            got.frame_last !== want.frame_last) begin
          errors++;
          if (errors < MAX_REPORTS)
            $display("%0t: mismatch expected r=%h g=%h b=%h last=%b frame_last=%b, %s%h %s%h %s%h %s%b %s%b",
                     $time, want.pix.r, want.pix.g, want.pix.b, want.run_last, want.frame_last,
                     "actual r=", got.pix.r, "g=", got.pix.g, "b=", got.pix.b,
                     "last=", got.run_last, "frame_last=", got.frame_last);
        end
      end
    end
  end

  function automatic int width_eff();
    if (width_q < 3) return 3;
    if (width_q > STORE_DEPTH) return STORE_DEPTH;
    return int'(width_q);
  endfunction

  function automatic int height_eff();
    if (height_q < 3) return 3;
    return int'(height_q);
  endfunction

  function automatic bit frame_waiting();
    return row_pos >= height_eff();
  endfunction

  // One channel of the sharpened centre; sh selects the channel in the word.
  function automatic logic [7:0] boost_chan(input int sh);
    int          sum;
    int          centre;
    int          d;
    int          v;
    int          k;
    logic [23:0] t;
    sum = 0;
    for (k = 0; k < 9; k++) begin
      t = win[k];
      if (k != 4) sum += int'(t[sh +: 8]);
    end
    t = win[4];
    centre = int'(t[sh +: 8]);
    d = centre - (sum / 8);
    // A zero difference is pushed upward like a positive one.
    if (d < 0) d = d - int'(sharp_q);
    else d = d + int'(sharp_q);
    v = centre + d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic predict(input logic op, input pix_t p, output int n,
                         output res_t r0, output res_t r1);
    int   w;
    int   h;
    int   c;
    int   r;
    int   k;
    bit   row_end;
    pix_t top;
    pix_t mid;
    res_t got [2];
    w = width_eff();
    h = height_eff();
    n = 0;
    got[0] = '0;
    got[1] = '0;
    if (op == OP_DRAIN) begin
      if (frame_waiting()) begin
        if (drain_pos >= w) drain_pos = w - 1;
        got[0].pix = newer_row[drain_pos];
        got[0].run_last = 1'b1;
        got[0].frame_last = (drain_pos >= w - 1);
        n = 1;
        if (got[0].frame_last) begin
          row_pos = 0;
          col_pos = 0;
          drain_pos = 0;
        end else begin
          drain_pos++;
        end
      end
    end else if (!frame_waiting()) begin
      c = col_pos;
      r = row_pos;
      if (c >= w) c = w - 1;
      row_end = (c >= w - 1);
      top = older_row[c];
      mid = newer_row[c];
      for (k = 0; k < 3; k++) begin
        win[k * 3]     = win[k * 3 + 1];
        win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = p;
      older_row[c] = mid;
      newer_row[c] = p;
      if (r >= 1 && c >= 1) begin
        if (r - 1 == 0 || r - 1 >= h - 1 || c - 1 == 0 || c - 1 >= w - 1)
          got[0].pix = win[4];
        else
          got[0].pix = {boost_chan(16), boost_chan(8), boost_chan(0)};
        got[0].run_last = !row_end;
        n = 1;
      end
      // The right border pixel of the output row leaves with the row end.
      if (r >= 1 && row_end) begin
        got[n].pix = mid;
        got[n].run_last = 1'b1;
        n++;
      end
      if (row_end) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    end
    r0 = got[0];
    r1 = got[1];
  endtask

  function automatic pix_t rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    return {r, g, b};
  endfunction

  function automatic res_t mk_res(input pix_t p, input logic rl, input logic fl);
    return {p, rl, fl};
  endfunction

  function automatic pix_t rand_pix();
    logic [31:0] v;
    v = $urandom;
    return v[23:0];
  endfunction

  // Content styles: plain noise, saturated channels, smooth area, spikes.
  function automatic pix_t gen_pix(input int mode, input pix_t base);
    logic [31:0] v;
    v = $urandom;
    case (mode)
      1: return {{8{v[0]}}, {8{v[1]}}, {8{v[2]}}};
      2: return {base.r ^ {5'd0, v[2:0]}, base.g ^ {5'd0, v[5:3]}, base.b ^ {5'd0, v[8:6]}};
      3: return (v[31:29] == 3'd0) ? ~base : base;
      default: return v[23:0];
    endcase
  endfunction

  task automatic add_cfg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    stim_row_t row;
    row = '{ROW_CFG, OP_PIXEL, '0, addr, data, EXP_NONE, '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_item(input logic op, input pix_t p, input exp_kind_e ek, input res_t er);
    stim_row_t row;
    row = '{ROW_ITEM, op, p, REG_SHARPNESS, '0, ek, er};
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge with the sender idle.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_SHARPNESS: sharp_q  = data[4:0];
      REG_WIDTH:     width_q  = data[10:0];
      REG_HEIGHT:    height_q = data[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Lower valid and wait until every predicted item has left the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_item(input logic op, input pix_t p, input exp_kind_e ek, input res_t er);
    int   n;
    res_t r0;
    res_t r1;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {p.b, p.g, p.r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(op, p, n, r0, r1);
    case (ek)
      EXP_MODEL: begin
        if (n > 0) expected_pixels.push_back(r0);
        if (n > 1) expected_pixels.push_back(r1);
      end
      EXP_ONE: expected_pixels.push_back(er);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Finish the current frame: pixels up to the last row, then the drain.
  task automatic run_frame(input int mode, input bit noisy);
    pix_t base;
    base = rand_pix();
    while (!frame_waiting()) begin
      // A drain in the middle of a frame is dropped by the block.
      if (noisy && $urandom_range(49) == 0) send_item(OP_DRAIN, rand_pix(), EXP_MODEL, '0);
      if ($urandom_range(199) == 0) settle();
      send_item(OP_PIXEL, gen_pix(mode, base), EXP_MODEL, '0);
      gen_count++;
    end
    if (noisy && $urandom_range(2) == 0) send_item(OP_PIXEL, rand_pix(), EXP_MODEL, '0);
    while (frame_waiting()) begin
      send_item(OP_DRAIN, rand_pix(), EXP_MODEL, '0);
      gen_count++;
    end
    if (noisy && $urandom_range(2) == 0) send_item(OP_DRAIN, rand_pix(), EXP_MODEL, '0);
  endtask

  task automatic random_settings();
    logic [31:0] v;
    logic [4:0]  sh;
    logic [10:0] w;
    logic [15:0] h;
    v = $urandom;
    case ($urandom_range(9))
      0: sh = 5'd1;
      1: sh = 5'd16;
      2: sh = 5'd0;
      3: sh = 5'd31;
      default: sh = v[4:0];
    endcase
    w = ($urandom_range(9) == 0) ? 11'($urandom_range(2)) : 11'($urandom_range(8, 3));
    h = ($urandom_range(9) == 0) ? 16'($urandom_range(2)) : 16'($urandom_range(6, 3));
    // Bits above the sharpness and width fields must be dropped by the block.
    write_reg(REG_SHARPNESS, {v[15:5], sh});
    write_reg(REG_WIDTH, {v[20:16], w});
    write_reg(REG_HEIGHT, h);
  endtask

  initial begin : stimulus
    pix_t p00, p01, p02, p10, p11, p12, p20, p21, p22;
    int   ph;
    int   k;
    int   n;
    for (k = 0; k < STORE_DEPTH; k++) begin
      older_row[k] = '0;
      newer_row[k] = '0;
    end
    for (k = 0; k < 9; k++) win[k] = '0;

    p00 = rgb(8'd255, 8'd0, 8'd0);
    p01 = rgb(8'd0, 8'd255, 8'd0);
    p02 = rgb(8'd0, 8'd0, 8'd255);
    p10 = rgb(8'd255, 8'd255, 8'd255);
    p11 = rgb(8'd0, 8'd0, 8'd0);
    p12 = rgb(8'd128, 8'd128, 8'd128);
    p20 = rgb(8'd1, 8'd2, 8'd3);
    p21 = rgb(8'd254, 8'd253, 8'd252);
    p22 = rgb(8'd0, 8'd255, 8'd255);

    // One 3x3 frame at the reset sharpness; both sizes saturate up to 3.
    add_cfg(REG_WIDTH, 16'd0);
    add_cfg(REG_HEIGHT, 16'd0);
    add_item(OP_DRAIN, rand_pix(), EXP_NONE, '0);
    add_item(OP_PIXEL, p00, EXP_NONE, '0);
    add_item(OP_PIXEL, p01, EXP_NONE, '0);
    add_item(OP_PIXEL, p02, EXP_NONE, '0);
    add_item(OP_PIXEL, p10, EXP_NONE, '0);
    add_item(OP_PIXEL, p11, EXP_ONE, mk_res(p00, 1'b1, 1'b0));
    add_item(OP_PIXEL, p12, EXP_MODEL, '0);
    add_item(OP_PIXEL, p20, EXP_NONE, '0);
    add_item(OP_PIXEL, p21, EXP_ONE, mk_res(p10, 1'b1, 1'b0));
    add_item(OP_PIXEL, p22, EXP_MODEL, '0);
    // The frame now waits for its drain, so a pixel is dropped.
    add_item(OP_PIXEL, rgb(8'd7, 8'd7, 8'd7), EXP_NONE, '0);
    add_item(OP_DRAIN, rand_pix(), EXP_ONE, mk_res(p20, 1'b1, 1'b0));
    add_item(OP_DRAIN, rand_pix(), EXP_ONE, mk_res(p21, 1'b1, 1'b0));
    add_item(OP_DRAIN, rand_pix(), EXP_ONE, mk_res(p22, 1'b1, 1'b1));
    add_item(OP_DRAIN, rand_pix(), EXP_NONE, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].addr, directed_rows[i].data);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].pix, directed_rows[i].ek,
                  directed_rows[i].er);
      end
    end

    ph = 0;
    while (gen_count < RANDOM_ITEMS) begin
      settle();
      calm = (ph >= 10 && ph < 16);
      case (ph)
        1: begin
          // Widest frame: the width saturates to the store depth. Part of the
          // drain runs, then a narrower width ends the drain at once.
          write_reg(REG_SHARPNESS, 16'($urandom_range(31)));
          write_reg(REG_WIDTH, 16'h07FF);
          write_reg(REG_HEIGHT, 16'd3);
          while (!frame_waiting()) send_item(OP_PIXEL, rand_pix(), EXP_MODEL, '0);
          repeat (5) send_item(OP_DRAIN, rand_pix(), EXP_MODEL, '0);
          settle();
          write_reg(REG_WIDTH, 16'd0);
          run_frame(0, 1'b0);
        end
        4: begin
          // Tallest height, cut short: after four rows and one pixel the
          // height drops below the row position and the frame must drain.
          write_reg(REG_WIDTH, 16'($urandom_range(5, 3)));
          write_reg(REG_HEIGHT, 16'hFFFF);
          n = 4 * width_eff() + 1;
          repeat (n) send_item(OP_PIXEL, rand_pix(), EXP_MODEL, '0);
          settle();
          write_reg(REG_HEIGHT, 16'd0);
          run_frame(0, 1'b1);
        end
        7: begin
          // Width shrinks while the column position is past its new end.
          write_reg(REG_WIDTH, 16'd8);
          write_reg(REG_HEIGHT, 16'd4);
          repeat (13) send_item(OP_PIXEL, rand_pix(), EXP_MODEL, '0);
          settle();
          write_reg(REG_WIDTH, 16'd4);
          run_frame(3, 1'b1);
        end
        default: begin
          random_settings();
          run_frame($urandom_range(3), 1'b1);
        end
      endcase
      ph++;
    end

    settle();
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("rgb_unsharp_3x3 regression: pass");
    end else begin
      $display("rgb_unsharp_3x3 regression: fail");
    end
    $finish;
  end

endmodule
